### sv/mck_pkg.sv
// Package for the Morse keyer: item types, mode codes and the Morse code table.
// Used by morse_code_keyer; no dependencies of its own.
package mck_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_PAUSE  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] character;
  } in_t;

  typedef struct packed {
    logic        tone_on;
    logic [14:0] tone_hz;
    logic [15:0] duration_ms;
    logic        last;
  } out_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TONE_FREQUENCY = 3'd0;
  localparam logic [2:0] REG_ELEMENT_GAP    = 3'd1;
  localparam logic [2:0] REG_DOT_DURATION   = 3'd2;
  localparam logic [2:0] REG_DASH_DURATION  = 3'd3;
  localparam logic [2:0] REG_CHARACTER_GAP  = 3'd4;

  localparam logic [15:0] ZERO_DEFAULT = 16'd100;

  localparam int MaxElems = 6;

  // Element count and pattern; first element sits in the top bit, 1 is a dash.
  typedef struct packed {
    logic [2:0]          count;
    logic [MaxElems-1:0] pattern;
  } code_t;

  localparam code_t LETTER_CODES [26] = '{
    '{3'd2, 6'b010000}, '{3'd4, 6'b100000}, '{3'd4, 6'b101000}, '{3'd3, 6'b100000},
    '{3'd1, 6'b000000}, '{3'd4, 6'b001000}, '{3'd3, 6'b110000}, '{3'd4, 6'b000000},
    '{3'd2, 6'b000000}, '{3'd4, 6'b011100}, '{3'd3, 6'b101000}, '{3'd4, 6'b010000},
    '{3'd2, 6'b110000}, '{3'd2, 6'b100000}, '{3'd3, 6'b111000}, '{3'd4, 6'b011000},
    '{3'd4, 6'b110100}, '{3'd3, 6'b010000}, '{3'd3, 6'b000000}, '{3'd1, 6'b100000},
    '{3'd3, 6'b001000}, '{3'd4, 6'b000100}, '{3'd3, 6'b011000}, '{3'd4, 6'b100100},
    '{3'd4, 6'b101100}, '{3'd4, 6'b110000}
  };

  localparam logic [MaxElems-1:0] DIGIT_PATTERNS [10] = '{
    6'b111110, 6'b011110, 6'b001110, 6'b000110, 6'b000010,
    6'b000000, 6'b100000, 6'b110000, 6'b111000, 6'b111100
  };

  localparam code_t PERIOD_CODE = '{3'd6, 6'b010101};
  localparam code_t HYPHEN_CODE = '{3'd6, 6'b100001};

  function automatic code_t code_of(input logic [7:0] ch);
    logic [7:0] lower_off;
    logic [7:0] upper_off;
    logic [7:0] digit_off;
    code_t      code;
    lower_off = ch - 8'd97;
    upper_off = ch - 8'd65;
    digit_off = ch - 8'd48;
    code = '{3'd0, '0};
    if (ch >= 8'd97 && ch <= 8'd122) begin
      code = LETTER_CODES[lower_off[4:0]];
    end else if (ch >= 8'd65 && ch <= 8'd90) begin
      code = LETTER_CODES[upper_off[4:0]];
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      code = '{3'd5, DIGIT_PATTERNS[digit_off[3:0]]};
    end else if (ch == 8'd46) begin
      code = PERIOD_CODE;
    end else if (ch == 8'd45) begin
      code = HYPHEN_CODE;
    end
    return code;
  endfunction

endpackage

### sv/morse_code_keyer.sv
// Morse keyer top level: microcode ROM, step counter and segment datapath.
// Depends on mck_pkg for item types and the Morse code table.
//
// Each accepted item (a character and a mode) is turned into a list of keyed
// segments: tone for each dot or dash, a silent element gap after it, and in
// text mode a trailing character gap (a space adds one more). A pause item
// gives one character gap; mode three and unknown number-mode characters give
// nothing. A small control program steps one control word per clock unless a
// step that emits is stalled; the item is taken only at the program's wait
// step, so no new item is taken until the last one is through. In text mode
// with n elements the program runs n+n tone/gap steps, four steps to dispatch,
// three to close and one more for a space. The output register frees the
// program while a segment waits.
// Configuration registers reset to 1; writing 0 to the tone frequency, dot or
// dash register stores 100.
module morse_code_keyer (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mck_pkg::in_t in_item,
  output logic         out_valid,
  input  logic         out_ready,
  output mck_pkg::out_t out_item,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_TONE,
    EMIT_EGAP,
    EMIT_CGAP
  } emit_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_NUMEND
  } last_sel_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_PAUSE,
    C_MODE3,
    C_NO_ELEM,
    C_MORE_ELEM,
    C_NOT_TEXT,
    C_NOT_SPACE
  } cond_t;

  typedef struct packed {
    logic      take;
    emit_t     emit;
    last_sel_t last_sel;
    logic      shift;
    cond_t     cond;
    logic [3:0] target;
  } uword_t;

  localparam logic [3:0] P_WAIT  = 4'd0;
  localparam logic [3:0] P_TONE  = 4'd4;
  localparam logic [3:0] P_CLOSE = 4'd6;
  localparam logic [3:0] P_FINAL = 4'd9;

  function automatic uword_t ucode(input logic [3:0] step);
    uword_t w;
    w = '{1'b0, EMIT_NONE, LAST_NO, 1'b0, C_NEVER, P_WAIT};
    case (step)
      4'd0: w = '{1'b1, EMIT_NONE, LAST_NO,     1'b0, C_NO_ITEM,   P_WAIT};
      4'd1: w = '{1'b0, EMIT_NONE, LAST_NO,     1'b0, C_PAUSE,     P_FINAL};
      4'd2: w = '{1'b0, EMIT_NONE, LAST_NO,     1'b0, C_MODE3,     P_WAIT};
      4'd3: w = '{1'b0, EMIT_NONE, LAST_NO,     1'b0, C_NO_ELEM,   P_CLOSE};
      4'd4: w = '{1'b0, EMIT_TONE, LAST_NO,     1'b0, C_NEVER,     P_WAIT};
      4'd5: w = '{1'b0, EMIT_EGAP, LAST_NUMEND, 1'b1, C_MORE_ELEM, P_TONE};
      4'd6: w = '{1'b0, EMIT_NONE, LAST_NO,     1'b0, C_NOT_TEXT,  P_WAIT};
      4'd7: w = '{1'b0, EMIT_NONE, LAST_NO,     1'b0, C_NOT_SPACE, P_FINAL};
      4'd8: w = '{1'b0, EMIT_CGAP, LAST_NO,     1'b0, C_NEVER,     P_WAIT};
      4'd9: w = '{1'b0, EMIT_CGAP, LAST_YES,    1'b0, C_ALWAYS,    P_WAIT};
      default: w = '{1'b0, EMIT_NONE, LAST_NO, 1'b0, C_ALWAYS, P_WAIT};
    endcase
    return w;
  endfunction

  logic [14:0] tone_frequency;
  logic [15:0] element_gap;
  logic [15:0] dot_duration;
  logic [15:0] dash_duration;
  logic [15:0] character_gap;

  logic [3:0]  pc;
  logic [1:0]  mode;
  logic        is_space;
  logic [2:0]  count;
  logic [mck_pkg::MaxElems-1:0] pattern;

  uword_t        uw;
  logic          go;
  logic          taken;
  logic          seg_last;
  mck_pkg::out_t seg;
  mck_pkg::code_t lookup;

  assign uw       = ucode(pc);
  assign in_ready = uw.take;
  assign lookup   = mck_pkg::code_of(in_item.character);
  // A step that emits waits until the output register is free.
  assign go = (uw.emit == EMIT_NONE) || !out_valid || out_ready;

  always_comb begin
    case (uw.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ITEM:   taken = !in_valid;
      C_PAUSE:     taken = (mode == mck_pkg::MODE_PAUSE);
      C_MODE3:     taken = (mode == mck_pkg::MODE_NONE);
      C_NO_ELEM:   taken = (count == 3'd0);
      C_MORE_ELEM: taken = (count > 3'd1);
      C_NOT_TEXT:  taken = (mode != mck_pkg::MODE_TEXT);
      C_NOT_SPACE: taken = !is_space;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.last_sel)
      LAST_YES:    seg_last = 1'b1;
      LAST_NUMEND: seg_last = (count == 3'd1) && (mode == mck_pkg::MODE_NUMBER);
      default:     seg_last = 1'b0;
    endcase
    seg.last = seg_last;
    case (uw.emit)
      EMIT_TONE: begin
        seg.tone_on     = 1'b1;
        seg.tone_hz     = tone_frequency;
        seg.duration_ms = pattern[mck_pkg::MaxElems-1] ? dash_duration : dot_duration;
      end
      EMIT_EGAP: begin
        seg.tone_on     = 1'b0;
        seg.tone_hz     = '0;
        seg.duration_ms = element_gap;
      end
      default: begin
        seg.tone_on     = 1'b0;
        seg.tone_hz     = '0;
        seg.duration_ms = character_gap;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_frequency <= 15'd1;
      element_gap    <= 16'd1;
      dot_duration   <= 16'd1;
      dash_duration  <= 16'd1;
      character_gap  <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        mck_pkg::REG_TONE_FREQUENCY: tone_frequency <= (cfg_data[14:0] == 15'd0) ?
                                       mck_pkg::ZERO_DEFAULT[14:0] : cfg_data[14:0];
        mck_pkg::REG_ELEMENT_GAP:    element_gap <= cfg_data;
        mck_pkg::REG_DOT_DURATION:   dot_duration <= (cfg_data == 16'd0) ?
                                       mck_pkg::ZERO_DEFAULT : cfg_data;
        mck_pkg::REG_DASH_DURATION:  dash_duration <= (cfg_data == 16'd0) ?
                                       mck_pkg::ZERO_DEFAULT : cfg_data;
        mck_pkg::REG_CHARACTER_GAP:  character_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= P_WAIT;
      out_valid <= 1'b0;
    end else begin
      if (go && uw.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        pc <= taken ? uw.target : pc + 4'd1;
      end
    end
  end

  // Datapath: load the item's code, shift out one element per element gap.
  always_ff @(posedge clk) begin
    if (uw.take && in_valid) begin
      mode     <= in_item.mode;
      is_space <= (in_item.character == 8'd32);
      count    <= lookup.count;
      pattern  <= lookup.pattern;
    end else if (go && uw.shift) begin
      count   <= count - 3'd1;
      pattern <= {pattern[mck_pkg::MaxElems-2:0], 1'b0};
    end
    if (go && uw.emit != EMIT_NONE) begin
      out_item <= seg;
    end
  end

endmodule
